// ===== rtl/lidar_ring_yaw_time_deskew_macros.svh =====
// assertion macros for the lidar deskew block
`ifndef LIDAR_RING_YAW_TIME_DESKEW_MACROS_SVH
`define LIDAR_RING_YAW_TIME_DESKEW_MACROS_SVH

`ifndef SYNTHESIS
`define LDSK_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("deskew implication check failed");
`define LDSK_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("deskew next-cycle check failed");
`else
`define LDSK_ASSERT_IMP(lbl, a, b)
`define LDSK_ASSERT_NXT(lbl, a, b)
`endif

`endif

// ===== rtl/ldsk_pkg.sv =====
// shared constants, types and tables for the lidar deskew block
`timescale 1ns / 1ps
package ldsk_pkg;

    localparam int MAX_RINGS    = 64;
    localparam int RING_W       = 6;
    localparam int RIDX_W       = $clog2(MAX_RINGS);
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 35;
    localparam int DVD_W        = 33;

    // floor(n / 1000) = (n >> 3) * ceil(2^37 / 125) >> 37 for n below 2^33
    localparam logic [31:0] RECIP_US = 32'd1099511628;
    localparam int          US_PRE   = 3;
    localparam int          US_SHIFT = 37;
    // floor(n / 1000000) = (n >> 6) * ceil(2^45 / 15625) >> 45 for n below 2^33
    localparam logic [31:0] RECIP_NS = 32'd2251799814;
    localparam int          NS_PRE   = 6;
    localparam int          NS_SHIFT = 45;

    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_GIVEN = 2'd1;
    localparam logic [1:0] MODE_CALC  = 2'd2;

    localparam logic [1:0] UNIT_S  = 2'd0;
    localparam logic [1:0] UNIT_MS = 2'd1;
    localparam logic [1:0] UNIT_US = 2'd2;
    localparam logic [1:0] UNIT_NS = 2'd3;

    localparam logic [1:0] REG_BLIND  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_UNIT   = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MODE,
        S_CORD,
        S_TIME,
        S_TMUL,
        S_GIVEN,
        S_GMUL,
        S_DIV,
        S_EMIT
    } ldsk_state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr_seen;
        logic [RIDX_W-1:0] addr;
    } ldsk_mem_req_t;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000028;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ldsk_ring_mem.sv =====
// per-ring store: start angle and last time in memory, seen flags in flops
`timescale 1ns / 1ps
module ldsk_ring_mem
    import ldsk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ldsk_mem_req_t         req,
    input  logic [ANGLE_BITS-1:0] wr_angle,
    input  logic [31:0]           wr_last,
    output logic                  rd_seen,
    output logic [ANGLE_BITS-1:0] rd_angle,
    output logic [31:0]           rd_last
);

    logic [ANGLE_BITS+31:0] mem [MAX_RINGS];
    logic [ANGLE_BITS+31:0] rd_data_reg;
    logic [MAX_RINGS-1:0]   seen_reg;
    logic                   rd_seen_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= {wr_angle, wr_last};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            rd_seen_reg <= 1'b0;
        end
        else
        begin
            if (req.clr_seen)
            begin
                seen_reg <= '0;
            end
            else if (req.wr_en)
            begin
                seen_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_seen_reg <= seen_reg[req.addr];
            end
        end
    end

    assign rd_seen  = rd_seen_reg;
    assign rd_angle = rd_data_reg[ANGLE_BITS+31:32];
    assign rd_last  = rd_data_reg[31:0];

endmodule

// ===== rtl/ldsk_cordic.sv =====
// iterative vectoring cordic giving the azimuth as a binary angle
`timescale 1ns / 1ps
module ldsk_cordic
    import ldsk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    output logic                  done,
    output logic [ANGLE_BITS-1:0] angle
);

    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, xs, ys, xi, yi;
    logic [31:0]          z_reg, z_next, z_round;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg, done_reg, zero_reg;

    assign xi = CW'(pos_x);
    assign yi = CW'(pos_y);
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;

    always_comb
    begin
        if (!y_reg[CW-1])
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_turn(step_reg);
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_turn(step_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // left half plane: turn by half a revolution first
            x_reg    <= pos_x[31] ? -xi : xi;
            y_reg    <= pos_x[31] ? -yi : yi;
            z_reg    <= pos_x[31] ? 32'h80000000 : 32'h0;
            zero_reg <= (pos_x == 32'sd0) && (pos_y == 32'sd0);
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign z_round = z_reg + (32'h1 << (32 - ANGLE_BITS - 1));
    assign angle   = zero_reg ? '0 : z_round[31 -: ANGLE_BITS];
    assign done    = done_reg;

endmodule

// ===== rtl/ldsk_div.sv =====
// reciprocal multiply for the us and ns time scaling: the pre-shifted operand is registered, then the product
`timescale 1ns / 1ps
module ldsk_div
    import ldsk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic             unit_ns,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [31:0] opd_reg;
    logic        ns_reg;
    logic [63:0] prod_reg;
    logic        mul_reg, done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // pre-shift drops the power of two part of the divisor
            opd_reg <= unit_ns ? 32'(dividend >> NS_PRE) : 32'(dividend >> US_PRE);
            ns_reg  <= unit_ns;
        end
        if (mul_reg)
        begin
            prod_reg <= 64'(opd_reg) * 64'(ns_reg ? RECIP_NS : RECIP_US);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= start;
            done_reg <= mul_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = ns_reg ? 32'(prod_reg >> NS_SHIFT) : 32'(prod_reg >> US_SHIFT);

endmodule

// ===== rtl/lidar_ring_yaw_time_deskew.sv =====
// lidar point deskew: offset time from azimuth, from given time or zero, blind range filter
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata x,y,z,intensity,ring,time; tuser scan_start
//  m_axis    out  tvalid/tready         tdata x,y,z,intensity,stamp time
//  cfg       in   cfg_we                cfg_addr, cfg_wdata
//
// one point at a time: range products first, then zero mode emits a zero time, ms mode passes
// the given time, seconds mode multiplies it by 1000, us/ns mode uses the reciprocal multiply and
// computed mode runs the cordic; the first point of a ring only stores its start angle
// range check uses one shared 32x32 multiplier for four products
// reset clears the ring seen flags at once, no clearing pass
// a kept point waits in the output register; a stalled output holds the next point
`timescale 1ns / 1ps
`include "lidar_ring_yaw_time_deskew_macros.svh"
module lidar_ring_yaw_time_deskew
    import ldsk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, intensity, ring, point_time, 2 zero bits
    input  logic [151:0] s_axis_tdata,
    // scan_start
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, out_intensity, stamp time
    output logic [143:0] m_axis_tdata
);

    ldsk_state_t state_reg, state_next;

    logic [31:0] blind_reg, period_reg;
    logic [1:0]  mode_reg, unit_reg;

    logic [31:0] x_reg, y_reg, z_reg, ptime_reg;
    logic [15:0] int_reg;
    logic [RING_W-1:0] ring_reg;

    logic [31:0] mul_a, mul_b, ax, ay, az;
    logic [63:0] prod_reg, r2_reg, b2_reg;
    logic [2:0]  cnt_reg;
    logic [31:0] time_reg, time_next;
    logic        time_ld;
    logic [ANGLE_BITS-1:0] ang_reg;

    logic          accept, ring_ok, keep, emit;
    ldsk_mem_req_t mem_req;
    logic          rd_seen;
    logic [ANGLE_BITS-1:0] rd_angle, cord_angle, wr_angle, d_ang;
    logic [31:0]   rd_last, wr_last;
    logic          cord_start, cord_done, div_start, div_done;
    logic [31:0]   div_q;
    logic [DVD_W-1:0] div_dvd;
    logic          div_ns;
    logic [32:0]   p33;
    logic [33:0]   p_add;

    logic          out_valid_reg;
    logic [143:0]  out_data_reg;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign ax = x_reg[31] ? -x_reg : x_reg;
    assign ay = y_reg[31] ? -y_reg : y_reg;
    assign az = z_reg[31] ? -z_reg : z_reg;
    assign keep = r2_reg > b2_reg;
    assign ring_ok = 32'(ring_reg) < 32'(MAX_RINGS);
    assign d_ang = rd_angle - ang_reg;
    assign div_ns = (unit_reg == UNIT_NS);

    // rounded product of angle difference and period, then wrap into the next turn
    assign p33   = 33'((prod_reg + 64'(32'h1 << (ANGLE_BITS - 1))) >> ANGLE_BITS);
    assign p_add = {1'b0, p33} + 34'(period_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blind_reg  <= 32'd655;
            mode_reg   <= MODE_CALC;
            unit_reg   <= UNIT_MS;
            period_reg <= 32'd6535446;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BLIND:  blind_reg  <= cfg_wdata;
                REG_MODE:   mode_reg   <= cfg_wdata[1:0];
                REG_UNIT:   unit_reg   <= cfg_wdata[1:0];
                REG_PERIOD: period_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_req    = '{rd_en: 1'b0, wr_en: 1'b0, clr_seen: 1'b0,
                       addr: ring_reg[RIDX_W-1:0]};
        time_next  = time_reg;
        time_ld    = 1'b0;
        wr_angle   = rd_angle;
        wr_last    = '0;
        cord_start = 1'b0;
        div_start  = 1'b0;
        div_dvd    = {1'b0, ptime_reg} + DVD_W'(500);
        mul_a      = ax;
        mul_b      = ax;
        emit       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                mem_req.clr_seen = accept && s_axis_tuser;
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (cnt_reg)
                    3'd0:    begin mul_a = ax; mul_b = ax; end
                    3'd1:    begin mul_a = ay; mul_b = ay; end
                    3'd2:    begin mul_a = az; mul_b = az; end
                    default: begin mul_a = blind_reg; mul_b = blind_reg; end
                endcase
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_MODE;
                end
            end
            S_MODE:
            begin
                time_ld   = 1'b1;
                time_next = '0;
                case (mode_reg)
                    MODE_CALC:
                    begin
                        if (ring_ok)
                        begin
                            cord_start     = 1'b1;
                            mem_req.rd_en  = 1'b1;
                            state_next     = S_CORD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    MODE_GIVEN: state_next = S_GIVEN;
                    default:    state_next = S_EMIT;
                endcase
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                mul_a = 32'(d_ang);
                mul_b = period_reg;
                if (!rd_seen)
                begin
                    // first point of the ring only sets its start angle
                    mem_req.wr_en = 1'b1;
                    wr_angle      = ang_reg;
                    wr_last       = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                time_ld = 1'b1;
                if (p33 < 33'(rd_last))
                begin
                    time_next = p_add[33:32] != 2'b00 ? 32'hFFFFFFFF : p_add[31:0];
                end
                else
                begin
                    time_next = p33[31:0];
                end
                wr_last       = time_next;
                mem_req.wr_en = 1'b1;
                state_next    = S_EMIT;
            end
            S_GIVEN:
            begin
                mul_a = ptime_reg;
                mul_b = 32'd1000;
                case (unit_reg)
                    UNIT_S:  state_next = S_GMUL;
                    UNIT_MS:
                    begin
                        time_ld    = 1'b1;
                        time_next  = ptime_reg;
                        state_next = S_EMIT;
                    end
                    UNIT_US:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        div_dvd    = {1'b0, ptime_reg} + DVD_W'(500000);
                        state_next = S_DIV;
                    end
                endcase
            end
            S_GMUL:
            begin
                time_ld    = 1'b1;
                time_next  = prod_reg[63:32] != 32'h0 ? 32'hFFFFFFFF : prod_reg[31:0];
                state_next = S_EMIT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    time_ld    = 1'b1;
                    time_next  = div_q;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!keep)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MUL)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (accept)
        begin
            x_reg     <= s_axis_tdata[31:0];
            y_reg     <= s_axis_tdata[63:32];
            z_reg     <= s_axis_tdata[95:64];
            int_reg   <= s_axis_tdata[111:96];
            ring_reg  <= s_axis_tdata[117:112];
            ptime_reg <= s_axis_tdata[149:118];
            r2_reg    <= '0;
        end
        else if (state_reg == S_MUL && cnt_reg != 3'd0)
        begin
            if (cnt_reg == 3'd4)
            begin
                b2_reg <= prod_reg;
            end
            else
            begin
                r2_reg <= r2_reg + prod_reg;
            end
        end
        if (cord_done)
        begin
            ang_reg <= cord_angle;
        end
        if (time_ld)
        begin
            time_reg <= time_next;
        end
        if (emit)
        begin
            out_data_reg <= {time_reg, int_reg, z_reg, y_reg, x_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    ldsk_ring_mem u_ring_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .wr_angle (wr_angle),
        .wr_last  (wr_last),
        .rd_seen  (rd_seen),
        .rd_angle (rd_angle),
        .rd_last  (rd_last)
    );

    ldsk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .pos_x (x_reg),
        .pos_y (y_reg),
        .done  (cord_done),
        .angle (cord_angle)
    );

    ldsk_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .unit_ns  (div_ns),
        .done     (div_done),
        .quotient (div_q)
    );

    `LDSK_ASSERT_IMP(a_busy_no_ready, state_reg != S_IDLE, !s_axis_tready)
    `LDSK_ASSERT_IMP(a_wr_in_time, mem_req.wr_en, (state_reg == S_TIME) || (state_reg == S_TMUL))
    `LDSK_ASSERT_IMP(a_div_given, div_start, mode_reg == MODE_GIVEN)
    `LDSK_ASSERT_NXT(a_cord_to_time, cord_done && state_reg == S_CORD, state_reg == S_TIME)

endmodule

// ===== tb/tb_lidar_ring_yaw_time_deskew.sv =====
// testbench for lidar_ring_yaw_time_deskew: streams points, predicts offset time and range keep
`timescale 1ns / 1ps
module tb_lidar_ring_yaw_time_deskew;
    import ldsk_pkg::*;

    localparam int RUN_LIMIT   = 1000000;
    localparam int SETTLE_CYCS = 120;

    typedef struct packed {
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] z;
        bit [15:0] inten;
        bit [31:0] t;
    } stamped_point_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;

    // shadow of the block's registers and ring store
    bit [31:0] sh_blind;
    bit [1:0]  sh_mode;
    bit [1:0]  sh_unit;
    bit [31:0] sh_period;
    bit        seen_tbl [MAX_RINGS];
    bit [15:0] start_tbl [MAX_RINGS];
    bit [31:0] last_tbl [MAX_RINGS];

    stamped_point_t kept_q[$];
    int  mismatches;
    int  cycles;
    int  src_idle_pct;
    int  snk_idle_pct;

    const bit [31:0] atan_lut [28] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    lidar_ring_yaw_time_deskew dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

    function automatic bit [15:0] cordic_bangle(longint px, longint py);
        bit [31:0] acc;
        bit [32:0] rnd;
        longint    xs;
        longint    ys;
        if (px == 0 && py == 0)
            return 16'd0;
        acc = 32'd0;
        if (px < 0)
        begin
            px = -px;
            py = -py;
            acc = 32'h80000000;
        end
        for (int i = 0; i < 28; i++)
        begin
            xs = px >>> i;
            ys = py >>> i;
            if (py >= 0)
            begin
                px = px + ys;
                py = py - xs;
                acc = acc + atan_lut[i];
            end
            else
            begin
                px = px - ys;
                py = py + xs;
                acc = acc - atan_lut[i];
            end
        end
        rnd = {1'b0, acc} + 33'h8000;
        return rnd[31:16];
    endfunction

    function automatic bit [31:0] given_to_ms(bit [31:0] pt);
        bit [63:0] v;
        case (sh_unit)
            UNIT_S:
            begin
                v = 64'(pt) * 64'd1000;
                return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
            end
            UNIT_US: return 32'((64'(pt) + 64'd500) / 64'd1000);
            UNIT_NS: return 32'((64'(pt) + 64'd500000) / 64'd1000000);
            default: return pt;
        endcase
    endfunction

    // returns 1 and fills the point when the block should emit one
    function automatic bit stamp_point(input bit ss, input bit [31:0] px, input bit [31:0] py,
                                       input bit [31:0] pz, input bit [15:0] inten,
                                       input bit [5:0] ring, input bit [31:0] pt,
                                       output stamped_point_t res);
        bit [31:0] tms;
        bit [15:0] ang;
        bit [15:0] d;
        bit [63:0] p;
        longint    sx;
        longint    sy;
        longint    sz;
        bit [65:0] r2;
        bit [65:0] b2;
        tms = 32'd0;
        sx = longint'(signed'(px));
        sy = longint'(signed'(py));
        sz = longint'(signed'(pz));
        res = '0;
        if (ss)
            foreach (seen_tbl[i]) seen_tbl[i] = 1'b0;
        if (sh_mode == MODE_CALC)
        begin
            ang = cordic_bangle(sx, sy);
            if (!seen_tbl[ring])
            begin
                seen_tbl[ring] = 1'b1;
                start_tbl[ring] = ang;
                last_tbl[ring] = 32'd0;
                return 1'b0;
            end
            d = start_tbl[ring] - ang;
            p = (64'(d) * 64'(sh_period) + 64'h8000) >> 16;
            if (p < 64'(last_tbl[ring]))
            begin
                p = p + 64'(sh_period);
                if (p > 64'hFFFFFFFF)
                    p = 64'hFFFFFFFF;
            end
            tms = p[31:0];
            last_tbl[ring] = tms;
        end
        else if (sh_mode == MODE_GIVEN)
            tms = given_to_ms(pt);
        r2 = 66'(sx * sx) + 66'(sy * sy) + 66'(sz * sz);
        b2 = 66'(64'(sh_blind) * 64'(sh_blind));
        if (!(r2 > b2))
            return 1'b0;
        res = '{x: px, y: py, z: pz, inten: inten, t: tms};
        return 1'b1;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        stamped_point_t want;
        stamped_point_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{x: m_axis_tdata[31:0], y: m_axis_tdata[63:32], z: m_axis_tdata[95:64],
                    inten: m_axis_tdata[111:96], t: m_axis_tdata[143:112]};
            if (kept_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: x=%h y=%h z=%h i=%h t=%h",
                             got.x, got.y, got.z, got.inten, got.t);
            end
            else
            begin
                want = kept_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h i=%h t=%h / got x=%h y=%h z=%h i=%h t=%h",
                                 want.x, want.y, want.z, want.inten, want.t,
                                 got.x, got.y, got.z, got.inten, got.t);
                end
            end
        end
    end

    task automatic send_point(input bit ss, input bit [31:0] px, input bit [31:0] py,
                              input bit [31:0] pz, input bit [15:0] inten,
                              input bit [5:0] ring, input bit [31:0] pt);
        stamped_point_t res;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ss;
        s_axis_tdata <= {2'b00, pt, ring, inten, pz, py, px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (stamp_point(ss, px, py, pz, inten, ring, pt, res))
            kept_q = {kept_q, res};
    endtask

    // let the block go quiet before a register write
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (kept_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BLIND:  sh_blind = val;
            REG_MODE:   sh_mode = val[1:0];
            REG_UNIT:   sh_unit = val[1:0];
            default:    sh_period = val;
        endcase
    endtask

    function automatic bit [31:0] rand_coord();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF);
            2:       return 32'd0;
            default: return 32'($signed($urandom_range(32'h3FFFFFF)) - 32'sh1FFFFFF);
        endcase
    endfunction

    function automatic bit [31:0] rand_time();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(32'hFFFFF);
            2:       return 32'hFFFFFFFF - $urandom_range(255);
            default: return $urandom_range(1000000);
        endcase
    endfunction

    task automatic test_directed_edges();
        drain_block();
        write_reg(REG_BLIND, 32'd0);
        write_reg(REG_MODE, 32'(MODE_CALC));
        send_point(1'b1, 32'h80000000, 32'd0, 32'd0, 16'hFFFF, 6'd0, 32'd0);
        send_point(1'b0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0, 32'hFFFFFFFF);
        send_point(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h1234, 6'd0, 32'd0);
        send_point(1'b0, 32'h00010000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 6'd0, 32'd0);
        send_point(1'b0, 32'hFFFF0000, 32'hFFFF0000, 32'd1, 16'h0, 6'd63, 32'd0);
        send_point(1'b0, 32'hFFFF0000, 32'h00010000, 32'd1, 16'h0, 6'd63, 32'd0);
        send_point(1'b1, 32'h00010000, 32'h0, 32'd0, 16'h5555, 6'd63, 32'd0);
        send_point(1'b0, 32'h00010000, 32'h00000100, 32'd0, 16'hAAAA, 6'd63, 32'd0);
        drain_block();
        // longest period for the computed offsets
        write_reg(REG_PERIOD, 32'hFFFFFFFF);
        send_point(1'b0, 32'h00010000, 32'hFFFF0000, 32'd0, 16'h1, 6'd63, 32'd0);
        send_point(1'b0, 32'h00010000, 32'h00010000, 32'd0, 16'h2, 6'd63, 32'd0);
        drain_block();
        write_reg(REG_PERIOD, 32'd1);
        send_point(1'b0, 32'hFFFF0000, 32'h00000010, 32'd0, 16'h3, 6'd63, 32'd0);
        drain_block();
        write_reg(REG_MODE, 32'(MODE_GIVEN));
        for (int u = 0; u < 4; u++)
        begin
            drain_block();
            write_reg(REG_UNIT, 32'(u));
            send_point(1'b0, 32'h00020000, 32'd0, 32'd0, 16'h0F0F, 6'd5, 32'hFFFFFFFF);
            send_point(1'b0, 32'h00020000, 32'd0, 32'd0, 16'hF0F0, 6'd5, 32'd499999);
            send_point(1'b0, 32'h00020000, 32'd0, 32'd0, 16'hF0F0, 6'd5, 32'd500);
        end
        drain_block();
        // undefined mode code behaves as zero time; wide value keeps low bits
        write_reg(REG_MODE, 32'hFFFFFFF3);
        send_point(1'b0, 32'h00030000, 32'd0, 32'd0, 16'h7, 6'd9, 32'h12345678);
        drain_block();
        write_reg(REG_BLIND, 32'hFFFFFFFF);
        send_point(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8, 6'd1, 32'd0);
        send_point(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h9, 6'd1, 32'd0);
        drain_block();
        write_reg(REG_BLIND, 32'h00010000);
        send_point(1'b0, 32'h00010000, 32'd0, 32'd0, 16'hA, 6'd1, 32'd0);
        send_point(1'b0, 32'h00010000, 32'd0, 32'd1, 16'hB, 6'd1, 32'd0);
    endtask

    task automatic test_given_and_zero(input int n);
        drain_block();
        write_reg(REG_BLIND, $urandom_range(32'h30000));
        write_reg(REG_MODE, $urandom_range(1) ? 32'(MODE_GIVEN) : 32'(MODE_ZERO));
        write_reg(REG_UNIT, $urandom_range(3));
        for (int i = 0; i < n; i++)
            send_point($urandom_range(9) == 0, rand_coord(), rand_coord(), rand_coord(),
                       16'($urandom), 6'($urandom), rand_time());
    endtask

    // well-formed scans: a start marker then sweeps over a few rings, some noise
    task automatic test_computed(input int n, input bit [31:0] period);
        bit [5:0] rbase;
        drain_block();
        write_reg(REG_MODE, 32'(MODE_CALC));
        write_reg(REG_PERIOD, period);
        write_reg(REG_BLIND, $urandom_range(2) == 0 ? 32'd655 : $urandom_range(32'h8000));
        rbase = 6'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(7) == 0)
                send_point(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                           16'($urandom), 6'($urandom), $urandom);
            else
                send_point(i % 48 == 0, rand_coord(), rand_coord(), rand_coord(),
                           16'($urandom), rbase + 6'($urandom_range(5)), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_BLIND;
        cfg_wdata = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        cycles = 0;
        src_idle_pct = 25;
        snk_idle_pct = 68;
        sh_blind = 32'd655;
        sh_mode = MODE_CALC;
        sh_unit = UNIT_MS;
        sh_period = 32'd6535446;
        foreach (seen_tbl[i]) seen_tbl[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values first: computed mode at the default period
        test_computed(20, 32'd6535446);
        test_directed_edges();
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 68 : 0;
            snk_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 25 : 0;
            test_computed(120, 32'd6535446);
            test_computed(40, $urandom);
            test_given_and_zero(80);
            test_computed(40, 32'hFFFFFFFF);
            test_given_and_zero(40);
        end
        drain_block();

        if (mismatches == 0 && kept_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ldsk_pkg.sv
rtl/ldsk_ring_mem.sv
rtl/ldsk_cordic.sv
rtl/ldsk_div.sv
rtl/lidar_ring_yaw_time_deskew.sv
tb/tb_lidar_ring_yaw_time_deskew.sv
